// ===== rtl/ecf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ecf_pkg: shared constants, register codes and control types
// for the envelope follower compressor; no dependencies

package ecf_pkg;

   // fixed-point widths
   localparam int ENV_W  = 24;   // envelope and reciprocal gain, q2.22
   localparam int MULT_W = 32;   // attack and release multipliers, q2.30
   localparam int GAIN_W = 17;   // channel gain and silence threshold, q1.16
   localparam int FIELDS = 4;    // sample fields carried by one word

   localparam logic [ENV_W-1:0] ENV_MAX  = 24'hFFFFFF;
   localparam logic [ENV_W-1:0] AMP_MIN  = 24'h200000;
   localparam logic [ENV_W-1:0] AMP_MAX  = 24'h800000;
   localparam logic [ENV_W-1:0] UNITY    = 24'h400000;
   // any envelope at or below this gives a quotient beyond the gain range
   localparam logic [ENV_W-1:0] RCP_SAT  = 24'h100000;

   localparam int RCP_STEPS = ENV_W;
   localparam int RCP_CNT_W = $clog2(RCP_STEPS + 1);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CH_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd4;

   localparam logic [MULT_W-1:0] MULT_RESET   = 32'h40000000;
   localparam logic [GAIN_W-1:0] CH_GAIN_RESET = 17'h10000;
   localparam logic [GAIN_W-1:0] THRESH_RESET  = 17'h00001;

   typedef struct packed {
      logic load;
      logic mute;
   } ecf_merge_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/ecf_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ecf_recip: iterative restoring divider giving floor(2^44 / envelope),
// one quotient bit a cycle; depends on ecf_pkg

module ecf_recip (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ecf_pkg::ENV_W-1:0] divisor,
   output logic                           done,
   output logic [ecf_pkg::ENV_W-1:0]      quotient
);
   import ecf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RCP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ENV_W-1:0]     rem_ff, rem_in;
   logic [ENV_W-1:0]     quo_ff, quo_in;
   logic [ENV_W-1:0]     div_ff, div_in;
   logic [ENV_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, 1'b0};
      if (start) begin
         div_in = divisor;
         if (divisor <= RCP_SAT) begin
            quo_in  = ENV_MAX;
            done_in = 1'b1;
         end else begin
            // dividend bits above the quotient range: 2^44 >> 24
            rem_in  = RCP_SAT;
            quo_in  = '0;
            cnt_in  = RCP_CNT_W'(RCP_STEPS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = ENV_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[ENV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ENV_W-1:0];
            quo_in = {quo_ff[ENV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == RCP_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/ecf_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ecf_lane: one channel lane, |sample| * gain * channel gain >> 38 with
// sign and saturation over three registered stages; depends on ecf_pkg

module ecf_lane #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [SAMPLE_WIDTH-1:0]    sample,
   input  wire logic [ecf_pkg::ENV_W-1:0]  gain,
   input  wire logic [ecf_pkg::GAIN_W-1:0] chan_gain,
   output logic                            done,
   output logic [SAMPLE_WIDTH-1:0]         result
);
   import ecf_pkg::*;

   localparam int A_W   = SAMPLE_WIDTH + ENV_W;
   localparam int HI_W  = A_W - 32;
   localparam int HP_W  = HI_W + GAIN_W;
   localparam int LP_W  = 32 + GAIN_W;
   localparam int SUM_W = HP_W + 1;
   localparam int S_W   = SUM_W - 6;

   logic                    v1_ff, v2_ff, done_ff;
   logic                    neg1_ff, neg1_in, neg2_ff;
   logic [SAMPLE_WIDTH-1:0] mag;
   logic [A_W-1:0]          a_ff, a_in;
   logic [LP_W-1:0]         lo_ff, lo_in;
   logic [HP_W-1:0]         hi_ff, hi_in;
   logic [SUM_W-1:0]        sum;
   logic [S_W-1:0]          scaled, lim, sat;
   logic [SAMPLE_WIDTH-1:0] res_mag;
   logic [SAMPLE_WIDTH-1:0] result_ff, result_in;

   // stage 1: magnitude times reciprocal gain
   always_comb begin
      neg1_in = sample[SAMPLE_WIDTH-1];
      mag     = neg1_in ? (~sample + 1'b1) : sample;
      a_in    = A_W'(mag) * A_W'(gain);
   end

   // stage 2: split product times channel gain
   always_comb begin
      lo_in = LP_W'(a_ff[31:0]) * LP_W'(chan_gain);
      hi_in = HP_W'(a_ff[A_W-1:32]) * HP_W'(chan_gain);
   end

   // stage 3: recombine, shift, saturate, restore sign
   always_comb begin
      sum     = SUM_W'(hi_ff) + SUM_W'(lo_ff[LP_W-1:32]);
      scaled  = sum[SUM_W-1:6];
      lim     = S_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}) + S_W'(neg2_ff);
      sat     = (scaled > lim) ? lim : scaled;
      res_mag = sat[SAMPLE_WIDTH-1:0];
      result_in = neg2_ff ? (~res_mag + 1'b1) : res_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
      if (start) begin
         a_ff    <= a_in;
         neg1_ff <= neg1_in;
      end
      if (v1_ff) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         neg2_ff <= neg1_ff;
      end
      if (v2_ff) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/ecf_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ecf_merge: gathers lane results and gain into the output word register,
// applies muting and zero fill for absent channels; depends on ecf_pkg

module ecf_merge #(
   parameter int CHANNELS     = 4,
   parameter int SAMPLE_WIDTH = 24,
   parameter int OUT_W        = 128
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire ecf_pkg::ecf_merge_ctl_type               ctl,
   input  wire logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0]    lane_res,
   input  wire logic [ecf_pkg::ENV_W-1:0]                gain,
   input  wire logic                                     rsp_tready,
   output logic                                          rsp_tvalid,
   output logic [OUT_W-1:0]                              rsp_tdata,
   output logic                                          free
);
   import ecf_pkg::*;

   localparam int PACK_W = FIELDS * SAMPLE_WIDTH + ENV_W;

   logic [FIELDS-1:0][SAMPLE_WIDTH-1:0] chan;
   logic [OUT_W-1:0]                    data_ff, data_in;
   logic                                valid_ff, valid_in;

   for (genvar c = 0; c < FIELDS; c++) begin : g_chan
      if (c < CHANNELS) begin : g_live
         assign chan[c] = ctl.mute ? '0 : lane_res[c];
      end else begin : g_absent
         assign chan[c] = '0;
      end
   end

   always_comb begin
      free     = !valid_ff || rsp_tready;
      data_in  = OUT_W'({gain, chan});
      valid_in = valid_ff && !rsp_tready;
      if (ctl.load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ctl.load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   // keeps the packing width tied to the port width
   if (PACK_W > OUT_W) begin : g_bad_width
      $error("output word narrower than its fields");
   end

endmodule

`default_nettype wire

// ===== rtl/envelope_follower_compressor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// envelope_follower_compressor: top level with register file, envelope
// tracking, sequencer, lanes and output merge; depends on ecf_pkg,
// ecf_recip, ecf_lane and ecf_merge
//
//   channel   direction  handshake              word
//   req_      in         req_tvalid/req_tready  sample_w, x, y, z
//   rsp_      out        rsp_tvalid/rsp_tready  out_w, x, y, z, applied_gain
//   csr_      in         csr_we                 index, write data
//
// one word at a time; the reciprocal divider iterates, one quotient bit a
// cycle, when the envelope is above 2^20, and gives all ones otherwise
// synchronous active-high reset: envelope 1.0, registers to their defaults
// a finished word waits in the output register; the next input word is
// taken meanwhile and held in the last step until that register frees

module envelope_follower_compressor #(
   parameter int CHANNELS     = 4,
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // sample_w, sample_x, sample_y, sample_z
   input  wire logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_w, out_x, out_y, out_z, applied_gain
   output logic [((4*SAMPLE_WIDTH+24+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [ecf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ecf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ecf_pkg::*;

   localparam int OUT_W = ((FIELDS * SAMPLE_WIDTH + ENV_W + 7) / 8) * 8;
   localparam int AMP_W = SAMPLE_WIDTH + 9;
   localparam int PROD_W = ENV_W + MULT_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL      = 3'd1;
   localparam logic [2:0] ST_UPD      = 3'd2;
   localparam logic [2:0] ST_RCP_GO   = 3'd3;
   localparam logic [2:0] ST_RCP_WAIT = 3'd4;
   localparam logic [2:0] ST_LANE     = 3'd5;
   localparam logic [2:0] ST_OUT      = 3'd6;

   // configuration registers
   logic              enable_ff;
   logic [MULT_W-1:0] attack_ff, release_ff;
   logic [GAIN_W-1:0] ch_gain_ff, thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         attack_ff  <= MULT_RESET;
         release_ff <= MULT_RESET;
         ch_gain_ff <= CH_GAIN_RESET;
         thresh_ff  <= THRESH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff  <= csr_wdata[0];
            CSR_ATTACK:    attack_ff  <= csr_wdata;
            CSR_RELEASE:   release_ff <= csr_wdata;
            CSR_CH_GAIN:   ch_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_THRESHOLD: thresh_ff  <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   logic [2:0] state_ff, state_in;
   logic       accept;
   logic [FIELDS-1:0][SAMPLE_WIDTH-1:0] sample_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // target amplitude from channel 0
   logic [SAMPLE_WIDTH-1:0] w_raw, w_mag;
   logic [AMP_W-1:0]        amp_wide;
   logic [ENV_W-1:0]        target_in, target_ff;

   assign w_raw = req_tdata[SAMPLE_WIDTH-1:0];
   assign w_mag = w_raw[SAMPLE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;

   if (SAMPLE_WIDTH <= 25) begin : g_amp_up
      assign amp_wide = AMP_W'(w_mag) << (25 - SAMPLE_WIDTH);
   end else begin : g_amp_down
      assign amp_wide = AMP_W'(w_mag >> (SAMPLE_WIDTH - 25));
   end

   always_comb begin
      priority if (!enable_ff) begin
         target_in = UNITY;
      end else if (amp_wide < AMP_W'(AMP_MIN)) begin
         target_in = AMP_MIN;
      end else if (amp_wide > AMP_W'(AMP_MAX)) begin
         target_in = AMP_MAX;
      end else begin
         target_in = amp_wide[ENV_W-1:0];
      end
   end

   // envelope step
   logic [ENV_W-1:0]  envelope_ff, envelope_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              up_ff, dn_ff;
   logic [PROD_W-31:0] prod_shift;
   logic [ENV_W-1:0]  prod_sat;

   assign prod_in    = PROD_W'(envelope_ff) *
                       PROD_W'((target_ff > envelope_ff) ? attack_ff : release_ff);
   assign prod_shift = prod_ff[PROD_W-1:30];
   assign prod_sat   = (prod_shift > (PROD_W-30)'(ENV_MAX)) ? ENV_MAX
                                                          : prod_shift[ENV_W-1:0];

   always_comb begin
      envelope_in = envelope_ff;
      if (state_ff == ST_UPD) begin
         if (up_ff) begin
            envelope_in = (prod_sat < target_ff) ? prod_sat : target_ff;
         end else if (dn_ff) begin
            envelope_in = (prod_sat > target_ff) ? prod_sat : target_ff;
         end
      end
   end

   // reciprocal
   logic             rcp_done;
   logic [ENV_W-1:0] rcp_gain;

   ecf_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_RCP_GO),
      .divisor  (envelope_ff),
      .done     (rcp_done),
      .quotient (rcp_gain)
   );

   // lanes
   logic [CHANNELS-1:0]                   lane_done;
   logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] lane_res;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      ecf_lane #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (rcp_done),
         .sample    (sample_ff[c]),
         .gain      (rcp_gain),
         .chan_gain (ch_gain_ff),
         .done      (lane_done[c]),
         .result    (lane_res[c])
      );
   end

   // output merge
   ecf_merge_ctl_type merge_ctl;
   logic              merge_free;

   assign merge_ctl.load = (state_ff == ST_OUT) && merge_free;
   assign merge_ctl.mute = (ch_gain_ff <= thresh_ff);

   ecf_merge #(
      .CHANNELS     (CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .OUT_W        (OUT_W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (merge_ctl),
      .lane_res   (lane_res),
      .gain       (rcp_gain),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .free       (merge_free)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_MUL;
         ST_MUL:      state_in = ST_UPD;
         ST_UPD:      state_in = ST_RCP_GO;
         ST_RCP_GO:   state_in = ST_RCP_WAIT;
         ST_RCP_WAIT: if (rcp_done) state_in = ST_LANE;
         ST_LANE:     if (&lane_done) state_in = ST_OUT;
         ST_OUT:      if (merge_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         envelope_ff <= UNITY;
      end else begin
         state_ff    <= state_in;
         envelope_ff <= envelope_in;
      end
      if (accept) begin
         target_ff <= target_in;
         for (int c = 0; c < FIELDS; c++) begin
            sample_ff[c] <= req_tdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH];
         end
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
         up_ff   <= target_ff > envelope_ff;
         dn_ff   <= target_ff < envelope_ff;
      end
   end

   // checks
   a_lane_in_step: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> state_ff == ST_LANE)
      else $error("lane result outside the lane step");

   a_rcp_in_step: assert property (@(posedge clock) disable iff (reset)
      rcp_done |-> state_ff == ST_RCP_WAIT)
      else $error("reciprocal finished outside its wait step");

   a_env_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_UPD |=> $stable(envelope_ff))
      else $error("envelope moved outside the update step");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      merge_ctl.load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while held");

endmodule

`default_nettype wire
